>>> rtl/owm_pkg.sv
// Shared types, codes and constants for the one-wire bus master timing unit.
// No dependencies; imported by every module of the block.
package owm_pkg;

	localparam int TICK_W  = 10;
	localparam int REG_W   = 10;
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 4;

	// Fixed slot timings, in ticks
	localparam logic [TICK_W:0] RESET_RECOVERY_US = 11'd20;
	localparam logic [TICK_W:0] READ_TAIL_US      = 11'd40;

	// Operating modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_RESET = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// Item kinds
	localparam logic [1:0] KIND_TICK = 2'd0;

	// Reset phases
	localparam logic [1:0] PH_LOW      = 2'd0;
	localparam logic [1:0] PH_RECOVER  = 2'd1;
	localparam logic [1:0] PH_PRESENCE = 2'd2;

	// Read phases
	localparam logic [1:0] PH_SLOT = 2'd0;
	localparam logic [1:0] PH_TAIL = 2'd1;

	// Register indexes
	localparam logic [2:0] REG_RESET_LOW      = 3'd0;
	localparam logic [2:0] REG_PRES_TIMEOUT   = 3'd1;
	localparam logic [2:0] REG_PRES_LOW_LIMIT = 3'd2;
	localparam logic [2:0] REG_WRITE_ONE_LOW  = 3'd3;
	localparam logic [2:0] REG_WRITE_ZERO_LOW = 3'd4;
	localparam logic [2:0] REG_WRITE_SLOT     = 3'd5;
	localparam logic [2:0] REG_READ_LOW       = 3'd6;
	localparam logic [2:0] REG_READ_SAMPLE    = 3'd7;

	localparam logic [REG_W-1:0] REG_RESET_VAL [NUM_REGS] = '{
		10'd500, 10'd200, 10'd225, 10'd5, 10'd60, 10'd65, 10'd2, 10'd7
	};

	typedef struct packed {
		logic [REG_W-1:0] reset_low;
		logic [REG_W-1:0] presence_timeout;
		logic [REG_W-1:0] presence_low_limit;
		logic [REG_W-1:0] write_one_low;
		logic [REG_W-1:0] write_zero_low;
		logic [REG_W-1:0] write_slot;
		logic [REG_W-1:0] read_low;
		logic [REG_W-1:0] read_sample;
	} owm_cfg_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [1:0]        phase;
		logic [TICK_W-1:0] tick_count;
		logic [2:0]        bit_index;
		logic [7:0]        shift_byte;
		logic              saw_low;
	} owm_state_t;

	typedef struct packed {
		logic       drive_low;
		logic       done_res;
		logic [7:0] read_data;
		logic       presence_error;
		logic       rejected;
		logic       busy_res;
	} owm_result_t;

endpackage

>>> rtl/owm_cfg_regs.sv
// Configuration register file of the one-wire bus master timing unit.
// Depends on owm_pkg.
module owm_cfg_regs
	import owm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0]     wr_data,
	output owm_cfg_t             cfg
);

	logic [REG_W-1:0] regs_q [NUM_REGS];

	// Indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= REG_RESET_VAL[i];
		end else if (wr_en && (wr_index[REG_IDX_W-1] == 1'b0)) begin
			regs_q[wr_index[2:0]] <= wr_data;
		end
	end

	always_comb begin
		cfg.reset_low          = regs_q[REG_RESET_LOW];
		cfg.presence_timeout   = regs_q[REG_PRES_TIMEOUT];
		cfg.presence_low_limit = regs_q[REG_PRES_LOW_LIMIT];
		cfg.write_one_low      = regs_q[REG_WRITE_ONE_LOW];
		cfg.write_zero_low     = regs_q[REG_WRITE_ZERO_LOW];
		cfg.write_slot         = regs_q[REG_WRITE_SLOT];
		cfg.read_low           = regs_q[REG_READ_LOW];
		cfg.read_sample        = regs_q[REG_READ_SAMPLE];
	end

endmodule

>>> rtl/owm_step.sv
// Next-state and result logic for one item of the one-wire bus master.
// Depends on owm_pkg.
module owm_step
	import owm_pkg::*;
(
	input  owm_cfg_t    cfg,
	input  owm_state_t  cur,
	input  logic [1:0]  kind,
	input  logic [7:0]  write_data,
	input  logic        line_in,
	output owm_state_t  nxt,
	output owm_result_t res
);

	logic [TICK_W:0]  tick_inc;
	logic [REG_W-1:0] low_time;
	logic             finish;
	logic             last_bit;

	always_comb begin
		tick_inc = {1'b0, cur.tick_count} + 11'd1;
		low_time = cur.shift_byte[0] ? cfg.write_one_low : cfg.write_zero_low;
		last_bit = (cur.bit_index == 3'd7);
		finish   = 1'b0;
		nxt      = cur;
		res      = '0;

		if (kind != KIND_TICK) begin
			if (cur.mode != MODE_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				nxt.mode       = kind;
				nxt.phase      = '0;
				nxt.tick_count = '0;
				nxt.bit_index  = '0;
				nxt.saw_low    = 1'b0;
				nxt.shift_byte = (kind == MODE_WRITE) ? write_data : 8'd0;
			end
		end else begin
			unique case (cur.mode)
				MODE_RESET: begin
					if (cur.phase == PH_LOW) begin
						res.drive_low  = 1'b1;
						nxt.tick_count = tick_inc[TICK_W-1:0];
						if (tick_inc >= {1'b0, cfg.reset_low}) begin
							nxt.phase      = PH_RECOVER;
							nxt.tick_count = '0;
						end
					end else if (cur.phase == PH_RECOVER) begin
						nxt.tick_count = tick_inc[TICK_W-1:0];
						if (tick_inc >= RESET_RECOVERY_US) begin
							nxt.phase      = PH_PRESENCE;
							nxt.tick_count = '0;
						end
					end else if (!cur.saw_low) begin
						if (!line_in) begin
							nxt.saw_low    = 1'b1;
							nxt.tick_count = 10'd1;
							if (cfg.presence_low_limit <= 10'd1) begin
								finish             = 1'b1;
								res.presence_error = 1'b1;
							end
						end else begin
							nxt.tick_count = tick_inc[TICK_W-1:0];
							if (tick_inc >= {1'b0, cfg.presence_timeout}) begin
								finish             = 1'b1;
								res.presence_error = 1'b1;
							end
						end
					end else begin
						if (line_in) begin
							finish = 1'b1;
						end else begin
							nxt.tick_count = tick_inc[TICK_W-1:0];
							if (tick_inc >= {1'b0, cfg.presence_low_limit}) begin
								finish             = 1'b1;
								res.presence_error = 1'b1;
							end
						end
					end
				end
				MODE_WRITE: begin
					res.drive_low  = (cur.tick_count < low_time);
					nxt.tick_count = tick_inc[TICK_W-1:0];
					if (tick_inc >= {1'b0, cfg.write_slot}) begin
						nxt.shift_byte = {1'b0, cur.shift_byte[7:1]};
						nxt.tick_count = '0;
						nxt.phase      = '0;
						if (last_bit) finish = 1'b1;
						else nxt.bit_index = cur.bit_index + 3'd1;
					end
				end
				MODE_READ: begin
					if (cur.phase == PH_SLOT) begin
						res.drive_low = (cur.tick_count < cfg.read_low);
						if (cur.tick_count >= cfg.read_sample) begin
							nxt.shift_byte = {line_in, cur.shift_byte[7:1]};
							nxt.phase      = PH_TAIL;
							nxt.tick_count = '0;
						end else begin
							nxt.tick_count = tick_inc[TICK_W-1:0];
						end
					end else begin
						nxt.tick_count = tick_inc[TICK_W-1:0];
						if (tick_inc >= READ_TAIL_US) begin
							nxt.tick_count = '0;
							nxt.phase      = '0;
							if (last_bit) begin
								finish        = 1'b1;
								res.read_data = cur.shift_byte;
							end else begin
								nxt.bit_index = cur.bit_index + 3'd1;
							end
						end
					end
				end
				default: begin
					// idle tick: release the line
				end
			endcase
		end

		if (finish) begin
			res.done_res   = 1'b1;
			nxt.mode       = MODE_IDLE;
			nxt.phase      = '0;
			nxt.tick_count = '0;
			nxt.bit_index  = '0;
			nxt.saw_low    = 1'b0;
		end

		res.busy_res = (nxt.mode != MODE_IDLE);
	end

endmodule

>>> rtl/one_wire_master_timing_unit.sv
// Top level of the one-wire bus master timing unit: stream ports, sequencer
// state register and result register. Depends on owm_pkg, owm_cfg_regs, owm_step.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tuser kind, s_tdata byte + line
//  m_      | out       | m_tvalid / m_tready | m_tdata result, m_tlast done
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (10-bit reg)
//
// Cycles: one request per clock unless the output stalls; its result appears
// in the output register on the next cycle. The only loop is the sequencer state
// register feeding the combinational step logic, so a tick or command can enter
// on every unstalled clock. Reset: arst_n clears the sequencer to idle, empties
// the output register and loads the register defaults. Stalls: a new request is
// taken whenever the output register is empty or being drained in the same cycle.
module one_wire_master_timing_unit
	import owm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [7:0] write_data, [8] line_in, rest zero
	input  logic [1:0]           s_tuser,   // [1:0] kind
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [0] drive_low, [8:1] read_data,
	                                        // [9] presence_error, [10] rejected,
	                                        // [11] busy_res, rest zero
	output logic                 m_tlast,   // done_res
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	owm_cfg_t    cfg;
	owm_state_t  state_q;
	owm_state_t  state_nxt;
	owm_result_t res_nxt;
	owm_result_t res_q;
	logic        m_valid_q;
	logic        s_accept;

	assign cfg_ready = 1'b1;

	owm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	owm_step u_step (
		.cfg        (cfg),
		.cur        (state_q),
		.kind       (s_tuser),
		.write_data (s_tdata[7:0]),
		.line_in    (s_tdata[8]),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Take a request when the result slot is free or emptying this cycle
	assign s_tready = !m_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	// Advance the sequencer only on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s_accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result payload: hold while stalled, no reset needed
	always_ff @(posedge clk) begin
		if (s_accept) res_q <= res_nxt;
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = res_q.done_res;
	assign m_tdata  = {4'd0, res_q.busy_res, res_q.rejected, res_q.presence_error,
		res_q.read_data, res_q.drive_low};

endmodule

>>> rtl/owm_checker.sv
// Port-level checks for the one-wire bus master timing unit, bound to the top.
// Depends on owm_pkg for the kind codes.
module owm_checker
	import owm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result dropped or changed");

	// A command request never drives the bus
	a_cmd_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != KIND_TICK) |=> m_tvalid && !m_tdata[0])
		else $error("command request drove the line");

	// A finished command leaves the master idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[11])
		else $error("done with busy set");

	// A rejection only happens while busy
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tdata[11] && !m_tlast)
		else $error("rejected while not busy");

	// Read byte and presence error are zero outside done
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[9:1] == 9'd0))
		else $error("result fields set without done");

endmodule

bind one_wire_master_timing_unit owm_checker u_owm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> verif/one_wire_master_timing_unit_tb.sv
// Self-checking testbench for one_wire_master_timing_unit: drives ticks and commands on the
// request stream, predicts every result with an in-bench sequencer model and checks them.
// Depends on owm_pkg and the one_wire_master_timing_unit RTL.
module one_wire_master_timing_unit_tb;
	import owm_pkg::*;

	// Command kinds share their codes with the sequencer modes
	localparam logic [1:0] KIND_RESET = MODE_RESET;
	localparam logic [1:0] KIND_WRITE = MODE_WRITE;
	localparam logic [1:0] KIND_READ  = MODE_READ;

	// How the bus answers while a command runs
	localparam int LINE_PLAN   = 0;	// high, except one low window
	localparam int LINE_RANDOM = 1;
	localparam int LINE_HIGH   = 2;
	localparam int LINE_LOW    = 3;

	localparam int RANDOM_REQS  = 220;
	localparam int DRAIN_CYCLES = 4;
	localparam int END_CYCLES   = 20;
	localparam int RUN_LIMIT    = 10_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;	// [7:0] write_data, [8] line_in, rest zero
	logic [1:0]           s_tuser;	// [1:0] kind
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;	// [0] drive_low, [8:1] read_data, [9] presence_error,
	                              	// [10] rejected, [11] busy_res, rest zero
	logic                 m_tlast;	// done_res
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	one_wire_master_timing_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Sequencer model state and timing registers
	logic [REG_W-1:0]  timing_reg [NUM_REGS];
	logic [1:0]        seq_mode;
	logic [1:0]        seq_phase;
	logic [TICK_W-1:0] seq_count;
	logic [2:0]        seq_bit;
	logic [7:0]        seq_byte;
	logic              seq_saw_low;

	owm_result_t pending_results [$];
	owm_result_t popped_result;

	int errors;
	int results_checked;
	int requests_sent;
	int work_reqs;
	int burst_left;
	int resets_done, presence_errors, writes_done, reads_done, rejects_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("%0t: run limit reached with %0d results pending", $time,
			pending_results.size());
		$display("one_wire_master_timing_unit verification failed");
		$finish;
	end

	task automatic clear_sequencer();
		timing_reg[REG_RESET_LOW]      = 10'd500;
		timing_reg[REG_PRES_TIMEOUT]   = 10'd200;
		timing_reg[REG_PRES_LOW_LIMIT] = 10'd225;
		timing_reg[REG_WRITE_ONE_LOW]  = 10'd5;
		timing_reg[REG_WRITE_ZERO_LOW] = 10'd60;
		timing_reg[REG_WRITE_SLOT]     = 10'd65;
		timing_reg[REG_READ_LOW]       = 10'd2;
		timing_reg[REG_READ_SAMPLE]    = 10'd7;
		seq_mode    = MODE_IDLE;
		seq_phase   = PH_LOW;
		seq_count   = '0;
		seq_bit     = '0;
		seq_byte    = '0;
		seq_saw_low = 1'b0;
	endtask

	// Advance the sequencer model by one request and return the line drive and status
	task automatic advance_sequencer(input logic [1:0] kind, input logic [7:0] wbyte,
			input logic line, output owm_result_t res);
		logic             finish;
		logic [REG_W-1:0] low_time;
		int               cnt;
		res    = '0;
		finish = 1'b0;
		cnt    = int'(seq_count);
		if (kind != KIND_TICK) begin
			if (seq_mode != MODE_IDLE) begin
				res.rejected = 1'b1;
				rejects_seen++;
			end else begin
				seq_mode    = kind;
				seq_phase   = PH_LOW;
				cnt         = 0;
				seq_bit     = '0;
				seq_saw_low = 1'b0;
				seq_byte    = (kind == KIND_WRITE) ? wbyte : 8'h00;
			end
		end else begin
			case (seq_mode)
				MODE_RESET: begin
					if (seq_phase == PH_LOW) begin
						res.drive_low = 1'b1;
						cnt++;
						if (cnt >= timing_reg[REG_RESET_LOW]) begin
							seq_phase = PH_RECOVER;
							cnt = 0;
						end
					end else if (seq_phase == PH_RECOVER) begin
						cnt++;
						if (cnt >= RESET_RECOVERY_US) begin
							seq_phase = PH_PRESENCE;
							cnt = 0;
						end
					end else if (!seq_saw_low) begin
						if (!line) begin
							seq_saw_low = 1'b1;
							cnt = 1;
							if (cnt >= timing_reg[REG_PRES_LOW_LIMIT]) begin
								finish = 1'b1;
								res.presence_error = 1'b1;
							end
						end else begin
							cnt++;
							if (cnt >= timing_reg[REG_PRES_TIMEOUT]) begin
								finish = 1'b1;
								res.presence_error = 1'b1;
							end
						end
					end else if (line) begin
						finish = 1'b1;
					end else begin
						cnt++;
						if (cnt >= timing_reg[REG_PRES_LOW_LIMIT]) begin
							finish = 1'b1;
							res.presence_error = 1'b1;
						end
					end
				end
				MODE_WRITE: begin
					low_time = seq_byte[0] ? timing_reg[REG_WRITE_ONE_LOW]
						: timing_reg[REG_WRITE_ZERO_LOW];
					res.drive_low = (seq_count < low_time);
					cnt++;
					if (cnt >= timing_reg[REG_WRITE_SLOT]) begin
						seq_byte = seq_byte >> 1;
						cnt = 0;
						seq_phase = PH_SLOT;
						if (seq_bit == 3'd7)
							finish = 1'b1;
						else
							seq_bit++;
					end
				end
				MODE_READ: begin
					if (seq_phase == PH_SLOT) begin
						res.drive_low = (seq_count < timing_reg[REG_READ_LOW]);
						if (seq_count >= timing_reg[REG_READ_SAMPLE]) begin
							// sampled bit enters at the top as the byte shifts right
							seq_byte = {line, seq_byte[7:1]};
							seq_phase = PH_TAIL;
							cnt = 0;
						end else begin
							cnt++;
						end
					end else begin
						cnt++;
						if (cnt >= READ_TAIL_US) begin
							cnt = 0;
							seq_phase = PH_SLOT;
							if (seq_bit == 3'd7) begin
								finish = 1'b1;
								res.read_data = seq_byte;
							end else begin
								seq_bit++;
							end
						end
					end
				end
				default: ;	// idle tick: release the line, nothing else
			endcase
		end
		if (finish) begin
			res.done_res = 1'b1;
			case (seq_mode)
				MODE_RESET: begin
					resets_done++;
					presence_errors += res.presence_error;
				end
				MODE_WRITE: writes_done++;
				default:    reads_done++;
			endcase
			seq_mode    = MODE_IDLE;
			seq_phase   = PH_LOW;
			cnt         = 0;
			seq_bit     = '0;
			seq_saw_low = 1'b0;
		end
		seq_count    = cnt[TICK_W-1:0];
		res.busy_res = (seq_mode != MODE_IDLE);
	endtask

	// Offer one request, wait for the handshake, then record its expected result.
	// The sender works in bursts; a gap between bursts drops valid.
	task automatic send_req(input logic [1:0] kind, input logic [7:0] wbyte,
			input logic line);
		owm_result_t want;
		int          gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'd0, line, wbyte};
		do @(posedge clk); while (!s_tready);
		if (kind != KIND_TICK || seq_mode != MODE_IDLE)
			work_reqs++;
		advance_sequencer(kind, wbyte, line, want);
		pending_results.push_back(want);
		requests_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Tick the running command to its end; line_sel picks what the bus answers
	task automatic finish_cmd(input int line_sel, input int low_at, input int low_len,
			input int reject_pct);
		int   n;
		logic line;
		n = 0;
		while (seq_mode != MODE_IDLE) begin
			if (reject_pct > 0 && $urandom_range(0, 99) < reject_pct) begin
				send_req(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				case (line_sel)
					LINE_PLAN:   line = !(n >= low_at && n < low_at + low_len);
					LINE_RANDOM: line = 1'($urandom_range(0, 1));
					LINE_HIGH:   line = 1'b1;
					default:     line = 1'b0;
				endcase
				send_req(KIND_TICK, 8'($urandom_range(0, 255)), line);
				n++;
			end
		end
	endtask

	task automatic run_cmd(input logic [1:0] kind, input logic [7:0] wbyte, input int line_sel,
			input int low_at, input int low_len);
		send_req(kind, wbyte, 1'($urandom_range(0, 1)));
		finish_cmd(line_sel, low_at, low_len, 0);
	endtask

	task automatic idle_noise(input int count);
		repeat (count) send_req(KIND_TICK, 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	// Hold requests and wait until every expected result has drained
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_timing(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS)
			timing_reg[idx[2:0]] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [REG_W-1:0] rst_low, pres_to, pres_lim,
			one_low, zero_low, slot, rd_low, rd_sample);
		drain_results();
		write_timing(REG_RESET_LOW, rst_low);
		write_timing(REG_PRES_TIMEOUT, pres_to);
		write_timing(REG_PRES_LOW_LIMIT, pres_lim);
		write_timing(REG_WRITE_ONE_LOW, one_low);
		write_timing(REG_WRITE_ZERO_LOW, zero_low);
		write_timing(REG_WRITE_SLOT, slot);
		write_timing(REG_READ_LOW, rd_low);
		write_timing(REG_READ_SAMPLE, rd_sample);
	endtask

	// Register defaults after reset: one full read byte
	task automatic test_power_on_defaults();
		run_cmd(KIND_READ, 8'hFF, LINE_RANDOM, 0, 0);
	endtask

	task automatic test_directed_cases();
		set_timing(10'd3, 10'd4, 10'd3, 10'd1, 10'd3, 10'd4, 10'd1, 10'd2);
		send_req(KIND_TICK, 8'hFF, 1'b0);
		send_req(KIND_TICK, 8'h00, 1'b1);
		// presence pulse, no device, bus stuck low
		run_cmd(KIND_RESET, 8'h00, LINE_PLAN, 3 + 20 + 1, 2);
		run_cmd(KIND_RESET, 8'h00, LINE_HIGH, 0, 0);
		run_cmd(KIND_RESET, 8'h00, LINE_LOW, 0, 0);
		run_cmd(KIND_WRITE, 8'h00, LINE_RANDOM, 0, 0);
		run_cmd(KIND_WRITE, 8'hFF, LINE_RANDOM, 0, 0);
		// every command kind while busy must be refused
		send_req(KIND_WRITE, 8'h3C, 1'b1);
		send_req(KIND_RESET, 8'h00, 1'b0);
		send_req(KIND_WRITE, 8'hC3, 1'b1);
		send_req(KIND_READ, 8'h55, 1'b0);
		finish_cmd(LINE_RANDOM, 0, 0, 0);
	endtask

	task automatic test_timing_extremes();
		set_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd2, 10'd1, 10'd2);
		run_cmd(KIND_RESET, 8'h00, LINE_PLAN, 1 + 20, 1);
		run_cmd(KIND_RESET, 8'h00, LINE_HIGH, 0, 0);
		run_cmd(KIND_WRITE, 8'h5A, LINE_RANDOM, 0, 0);

		// zero registers end each interval after one tick; an index past the
		// register file must leave the timing untouched
		set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		write_timing(REG_IDX_W'(NUM_REGS + $urandom_range(0, 7)),
			REG_W'($urandom_range(1, 1023)));
		run_cmd(KIND_RESET, 8'h00, LINE_HIGH, 0, 0);
		run_cmd(KIND_RESET, 8'h00, LINE_PLAN, 20, 3);
		run_cmd(KIND_WRITE, 8'hA5, LINE_RANDOM, 0, 0);

		// low times longer than the slot, read pulse running past the sample tick
		set_timing(10'd2, 10'd3, 10'd2, 10'd9, 10'd1023, 10'd6, 10'd1023, 10'd3);
		run_cmd(KIND_WRITE, 8'h5A, LINE_RANDOM, 0, 0);
		run_cmd(KIND_READ, 8'h00, LINE_RANDOM, 0, 0);
	endtask

	// Short timings so many commands complete; most resets see a proper presence pulse
	task automatic test_random_traffic();
		logic [REG_W-1:0] rl, pto, plim;
		int round_start, pick, low_at, low_len;
		work_reqs = 0;
		while (work_reqs < RANDOM_REQS) begin
			rl   = REG_W'($urandom_range(1, 12));
			pto  = REG_W'($urandom_range(1, 12));
			plim = REG_W'($urandom_range(1, 12));
			set_timing(rl, pto, plim, REG_W'($urandom_range(1, 8)),
				REG_W'($urandom_range(1, 8)), REG_W'($urandom_range(2, 10)),
				REG_W'($urandom_range(1, 6)), REG_W'($urandom_range(2, 8)));
			round_start = work_reqs;
			while (work_reqs - round_start < 80 && work_reqs < RANDOM_REQS) begin
				pick = $urandom_range(0, 19);
				if (pick < 2) begin
					idle_noise($urandom_range(1, 5));
				end else if (pick < 10) begin
					if ($urandom_range(0, 3) != 0) begin
						low_at  = rl + 20 + $urandom_range(0, pto - 1);
						low_len = (plim > 1) ? $urandom_range(1, plim - 1) : 1;
					end else begin
						low_at  = $urandom_range(0, rl + 20 + pto + 3);
						low_len = $urandom_range(0, plim + 3);
					end
					send_req(KIND_RESET, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					finish_cmd(LINE_PLAN, low_at, low_len, 5);
				end else begin
					send_req((pick < 16) ? KIND_WRITE : KIND_READ,
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					finish_cmd(LINE_RANDOM, 0, 0, 3);
				end
			end
		end
	endtask

	// Receiver: switches between random stall patterns, including free-running stretches
	initial begin
		int stall_kind, stall_left, stall_phase;
		m_tready    = 1'b0;
		stall_left  = 0;
		stall_phase = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_kind = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			stall_phase = (stall_phase + 1) % 5;
			case (stall_kind)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (stall_phase != 0);
			endcase
		end
	end

	task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending: expected none, actual %h",
					$time, m_tdata);
			end else begin
				popped_result = pending_results.pop_front();
				results_checked++;
				check_field("drive_low", 8'(popped_result.drive_low), 8'(m_tdata[0]));
				check_field("read_data", popped_result.read_data, m_tdata[8:1]);
				check_field("presence_error", 8'(popped_result.presence_error),
					8'(m_tdata[9]));
				check_field("rejected", 8'(popped_result.rejected), 8'(m_tdata[10]));
				check_field("busy_res", 8'(popped_result.busy_res), 8'(m_tdata[11]));
				check_field("padding", 8'h00, 8'(m_tdata[15:12]));
				check_field("done_res", 8'(popped_result.done_res), 8'(m_tlast));
			end
		end
	end

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = KIND_TICK;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		errors = 0;
		results_checked = 0;
		requests_sent = 0;
		work_reqs = 0;
		burst_left = 0;
		resets_done = 0;
		presence_errors = 0;
		writes_done = 0;
		reads_done = 0;
		rejects_seen = 0;
		clear_sequencer();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_defaults();
		test_directed_cases();
		test_timing_extremes();
		test_random_traffic();

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		$display("run covered %0d requests and %0d checked results", requests_sent,
			results_checked);
		$display("commands: %0d resets (%0d with presence error), %0d writes, %0d reads, %0d refused",
			resets_done, presence_errors, writes_done, reads_done, rejects_seen);
		if (errors == 0) begin
			$display("one_wire_master_timing_unit verification clean");
		end else begin
			$display("one_wire_master_timing_unit verification failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/owm_pkg.sv
rtl/owm_cfg_regs.sv
rtl/owm_step.sv
rtl/one_wire_master_timing_unit.sv
rtl/owm_checker.sv
verif/one_wire_master_timing_unit_tb.sv
